// ===== rtl/core/mhpq_pkg.sv =====
// mhpq_pkg: shared types and constants of the max-heap priority queue
// used by the top level and its checker; no dependencies
`default_nettype none

package mhpq_pkg;

   // default number of keys the queue can hold
   localparam int DEFAULT_CAPACITY = 16;

   // field widths
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request kinds
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHK,
      S_UP_CMP,
      S_DEL_ROOT,
      S_DEL_LAST,
      S_DN_L,
      S_DN_R,
      S_DN_CMP,
      S_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/mhpq_ram.sv =====
// mhpq_ram: generic single-write, single-read memory with registered read
// no package dependencies
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, returns old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/max_heap_priority_queue.sv =====
// max_heap_priority_queue: binary max-heap of signed keys, insert or delete-max
// depends on mhpq_pkg and mhpq_ram
// an insert climbs level by level and a delete descends level by level before the response;
//   overflow and underflow go straight to the response state
// one transaction at a time, each level paced by the one store read port
// reset: synchronous, active high; clears the count and control, store left as is
`default_nettype none

module max_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [mhpq_pkg::KEY_W-1:0] req_tdata,  // [31:0] key
   input  wire logic [0:0]                 req_tuser,  // [0] mode
   // response channel
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [39:0]                     rsp_tdata,  // [31:0] removed_max, [36:32] entry_count
   output logic [mhpq_pkg::STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   import mhpq_pkg::*;

   localparam int PW = $clog2(CAPACITY + 1);  // heap position / count width
   localparam int AW = $clog2(CAPACITY);      // store address width

   state_type           state_ff, state_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PW-1:0]       count_ff, count_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    child_ff, child_in;
   logic                left_win_ff, left_win_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [KEY_W-1:0]    removed_ff, removed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [KEY_W-1:0]    out_removed_ff, out_removed_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [KEY_W-1:0]    wr_data;
   logic [AW-1:0]       rd_addr;
   logic [KEY_W-1:0]    rd_data;

   logic                req_fire;
   logic                rsp_free;
   logic                is_full;
   logic                is_empty;
   logic                is_root;
   logic [PW-1:0]       pos_m1;
   logic [PW-1:0]       parent;
   logic [PW-1:0]       parent_m1;
   logic [PW-1:0]       count_m1;
   logic [PW:0]         left;
   logic [PW:0]         right;
   logic [PW:0]         left_m1;
   logic [PW:0]         right_m1;
   logic [PW:0]         count_ext;
   logic                left_ok;
   logic                right_ok;
   logic [KEY_W-1:0]    cmp_a;
   logic [KEY_W-1:0]    cmp_b;
   logic                cmp_gt;
   logic [PW+COUNT_W-1:0] count_wide;

   // key store
   mhpq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshake and position arithmetic
   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign is_full   = (count_ff >= PW'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign is_root   = (pos_ff == PW'(1));
   assign pos_m1    = pos_ff - PW'(1);
   assign parent    = pos_ff >> 1;
   assign parent_m1 = parent - PW'(1);
   assign count_m1  = count_ff - PW'(1);
   assign left      = {pos_ff, 1'b0};
   assign right     = {pos_ff, 1'b1};
   assign left_m1   = left - (PW+1)'(1);
   assign right_m1  = right - (PW+1)'(1);
   assign count_ext = {1'b0, count_ff};
   assign left_ok   = (left <= count_ext);
   assign right_ok  = (right <= count_ext);
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   // shared signed comparator: moving key against its parent on the way up,
   // child against the moving key or left child on the way down
   assign cmp_a  = (state_ff == S_UP_CMP) ? key_ff : rd_data;
   assign cmp_b  = (state_ff == S_UP_CMP) ? rd_data :
                   (state_ff == S_DN_CMP && left_win_ff) ? child_ff : key_ff;
   assign cmp_gt = ($signed(cmp_a) > $signed(cmp_b));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == MODE_INSERT) begin
                  state_in = is_full ? S_RESP : S_UP_CHK;
               end else begin
                  state_in = is_empty ? S_RESP : S_DEL_ROOT;
               end
            end
         end
         S_UP_CHK:   state_in = is_root ? S_RESP : S_UP_CMP;
         S_UP_CMP:   state_in = cmp_gt ? S_UP_CHK : S_RESP;
         S_DEL_ROOT: state_in = S_DEL_LAST;
         S_DEL_LAST: state_in = (count_ff == PW'(1)) ? S_RESP : S_DN_L;
         S_DN_L:     state_in = left_ok ? S_DN_R : S_RESP;
         S_DN_R: begin
            if (right_ok) begin
               state_in = S_DN_CMP;
            end else begin
               state_in = cmp_gt ? S_DN_L : S_RESP;
            end
         end
         S_DN_CMP:   state_in = (cmp_gt || left_win_ff) ? S_DN_L : S_RESP;
         S_RESP:     state_in = rsp_free ? S_IDLE : S_RESP;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      pos_in         = pos_ff;
      count_in       = count_ff;
      key_in         = key_ff;
      child_in       = child_ff;
      left_win_in    = left_win_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      out_status_in  = out_status_ff;
      out_removed_in = out_removed_ff;
      out_count_in   = out_count_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_m1[AW-1:0];
      wr_data        = key_ff;
      rd_addr        = '0;
      case (state_ff)
         S_IDLE: begin
            // root is read here so a delete finds it in S_DEL_ROOT
            if (req_fire) begin
               status_in  = STATUS_OK;
               removed_in = '0;
               key_in     = req_tdata;
               if (req_tuser[0] == MODE_INSERT) begin
                  if (is_full) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     count_in = count_ff + PW'(1);
                     pos_in   = count_ff + PW'(1);
                  end
               end else if (is_empty) begin
                  status_in = STATUS_UNDERFLOW;
               end
            end
         end
         S_UP_CHK: begin
            if (is_root) begin
               wr_en = 1'b1;
            end else begin
               rd_addr = parent_m1[AW-1:0];
            end
         end
         S_UP_CMP: begin
            // smaller parent moves down into the hole, else the key is written there
            wr_en = 1'b1;
            if (cmp_gt) begin
               wr_data = rd_data;
               pos_in  = parent;
            end
         end
         S_DEL_ROOT: begin
            removed_in = rd_data;
            rd_addr    = count_m1[AW-1:0];
         end
         S_DEL_LAST: begin
            key_in   = rd_data;
            count_in = count_m1;
            pos_in   = PW'(1);
         end
         S_DN_L: begin
            if (left_ok) begin
               rd_addr = left_m1[AW-1:0];
            end else begin
               wr_en = 1'b1;
            end
         end
         S_DN_R: begin
            child_in    = rd_data;
            left_win_in = cmp_gt;
            if (right_ok) begin
               rd_addr = right_m1[AW-1:0];
            end else begin
               wr_en = 1'b1;
               if (cmp_gt) begin
                  wr_data = rd_data;
                  pos_in  = left[PW-1:0];
               end
            end
         end
         S_DN_CMP: begin
            // larger child, left on a tie, moves up into the hole if it beats the key, else the key is written there
            wr_en = 1'b1;
            if (cmp_gt) begin
               wr_data = rd_data;
               pos_in  = right[PW-1:0];
            end else if (left_win_ff) begin
               wr_data = child_ff;
               pos_in  = left[PW-1:0];
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               out_status_in  = status_ff;
               out_removed_in = removed_ff;
               out_count_in   = count_wide[COUNT_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      key_ff         <= key_in;
      child_ff       <= child_in;
      left_win_ff    <= left_win_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      out_status_ff  <= out_status_in;
      out_removed_ff <= out_removed_in;
      out_count_ff   <= out_count_in;
   end

   // response outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {3'b000, out_count_ff, out_removed_ff};

endmodule

`default_nettype wire

// ===== rtl/core/mhpq_chk.sv =====
// mhpq_chk: port-level checker for the max-heap priority queue, bound to the top
// depends on mhpq_pkg
`default_nettype none

module mhpq_chk #(
   parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic [mhpq_pkg::KEY_W-1:0] req_tdata,
   input wire logic [0:0]                 req_tuser,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [39:0]                rsp_tdata,
   input wire logic [mhpq_pkg::STATUS_W-1:0] rsp_tuser
);

   import mhpq_pkg::*;

   // stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a waiting request stays offered and unchanged until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("request changed while waiting");

   // an accepted request keeps the queue busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken back to back");

   // underflow leaves an empty queue and no removed key
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_UNDERFLOW |-> rsp_tdata[36:0] == 37'd0)
      else $error("underflow with nonzero payload");

   // overflow reports a full queue and no removed key
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OVERFLOW |->
         rsp_tdata[31:0] == 32'd0 && rsp_tdata[36:32] == 5'(CAPACITY))
      else $error("overflow with wrong payload");

endmodule

bind max_heap_priority_queue mhpq_chk #(.CAPACITY(CAPACITY)) u_mhpq_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
